### design/ctlex_pkg.sv
package ctlex_pkg;

  localparam logic [2:0] KIND_NUMBER = 3'd0;
  localparam logic [2:0] KIND_STRING = 3'd1;
  localparam logic [2:0] KIND_IDENT  = 3'd2;
  localparam logic [2:0] KIND_OPER   = 3'd3;
  localparam logic [2:0] KIND_PUNCT  = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;
  localparam logic [2:0] KIND_STRBYTE = 3'd6;

  localparam int KW_CHARS   = 7;
  localparam int KW_ENTRIES = 14;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [23:0] COUNT_MAX  = 24'hFFFFFF;
  localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_ENTRIES] = '{
    {"int", 32'd0}, {"char", 24'd0}, {"if", 40'd0}, {"else", 24'd0},
    {"FILE", 24'd0}, {"return", 8'd0}, {"printf", 8'd0}, {"memcmp", 8'd0},
    {"malloc", 8'd0}, {"memchr", 8'd0}, "memmove", {"fopen", 16'd0},
    {"fread", 16'd0}, {"exit", 24'd0}
  };
  localparam logic [2:0] KW_LEN [KW_ENTRIES] = '{
    3'd3, 3'd4, 3'd2, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd7, 3'd5, 3'd5, 3'd4
  };
  localparam logic [3:0] KW_CODE [KW_ENTRIES] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd2, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12,
    4'd13
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [7:0]  second;
    logic [3:0]  keyword;
    logic [23:0] start;
    logic [15:0] length;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t lead;
    result_t tail;
  } group_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b == 8'h5F) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  // First character of an operator: * / + - < = > | & !
  function automatic logic is_op_lead(input logic [7:0] b);
    return (b == 8'h2A) || (b == 8'h2F) || (b == 8'h2B) || (b == 8'h2D) ||
           (b == 8'h3C) || (b == 8'h3D) || (b == 8'h3E) || (b == 8'h7C) ||
           (b == 8'h26) || (b == 8'h21);
  endfunction

  // Second character of an operator: = & |
  function automatic logic is_op_tail(input logic [7:0] b);
    return (b == 8'h3D) || (b == 8'h26) || (b == 8'h7C);
  endfunction

  // Punctuation: ( ) { } , ;
  function automatic logic is_punct(input logic [7:0] b);
    return (b == 8'h28) || (b == 8'h29) || (b == 8'h7B) || (b == 8'h7D) ||
           (b == 8'h2C) || (b == 8'h3B);
  endfunction

  function automatic logic [3:0] keyword_of(input logic [8*KW_CHARS-1:0] word,
                                            input logic [15:0] len);
    logic [3:0] code;
    code = 4'd0;
    for (int i = 0; i < KW_ENTRIES; i++) begin
      if ((word == KW_TEXT[i]) && (len == {13'd0, KW_LEN[i]})) begin
        code = KW_CODE[i];
      end
    end
    return code;
  endfunction

  function automatic logic [23:0] inc_sat24(input logic [23:0] x);
    return (x == COUNT_MAX) ? x : x + 24'd1;
  endfunction

  function automatic logic [15:0] inc_sat16(input logic [15:0] x);
    return (x == LENGTH_MAX) ? x : x + 16'd1;
  endfunction

endpackage

### design/c_subset_token_lexer.sv
// Channel  Handshake                  Payload
// text     text_valid / text_ready    text_byte
// token    token_valid / token_ready  token_kind, token_value, second_char,
//                                     keyword_code, start_offset, token_length,
//                                     last_of_run
//
// One source byte is taken per cycle while the four-entry result queue has room.
// Each byte yields zero, one or two tokens; the output stage sends one token per
// cycle unless token_ready stalls it, so the two tokens of a byte leave in turn.
// A token passes through the result queue and the output register before it
// appears at the output. Reset is synchronous and clears the lexer state, empties
// the queue and clears the output valid flag.
module c_subset_token_lexer #(
  parameter int MAX_TEXT = 16777216,
  parameter int NAME_BUFFER_CHARS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [2:0]  token_kind,
  output logic [31:0] token_value,
  output logic [7:0]  second_char,
  output logic [3:0]  keyword_code,
  output logic [23:0] start_offset,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  localparam int CNT_W = $clog2(ctlex_pkg::QUEUE_DEPTH + 1);

  logic               accept;
  logic               push;
  logic               pop;
  logic               sel;
  ctlex_pkg::group_t  group;
  ctlex_pkg::group_t  head;
  ctlex_pkg::result_t token;
  logic [CNT_W-1:0]   count;

  assign text_ready = (count != CNT_W'(ctlex_pkg::QUEUE_DEPTH));
  assign accept = text_valid && text_ready;

  ctlex_front #(
    .MAX_TEXT(MAX_TEXT),
    .NAME_BUFFER_CHARS(NAME_BUFFER_CHARS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .text_byte(text_byte),
    .push(push),
    .group(group)
  );

  ctlex_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(group),
    .pop(pop),
    .head(head),
    .count(count)
  );

  ctlex_back u_back (
    .clk(clk),
    .rst(rst),
    .nonempty(count != '0),
    .head(head),
    .pop(pop),
    .sel(sel),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token(token),
    .last(last_of_run)
  );

  assign token_kind = token.kind;
  assign token_value = token.value;
  assign second_char = token.second;
  assign keyword_code = token.keyword;
  assign start_offset = token.start;
  assign token_length = token.length;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ctlex_pkg::QUEUE_DEPTH))
    else $error("result queue count beyond its depth");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token_kind == ctlex_pkg::KIND_END) |-> last_of_run)
    else $error("end token is not the last token of its byte");

  a_sel_has_head: assert property (@(posedge clk) disable iff (rst)
    sel |-> (count != '0))
    else $error("second token pending with an empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> text_ready)
    else $error("queue written while full");
`endif

endmodule

### design/ctlex_front.sv
module ctlex_front #(
  parameter int MAX_TEXT = 16777216,
  parameter int NAME_BUFFER_CHARS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  output logic                push,
  output ctlex_pkg::group_t   group
);

  localparam int IDX_W = $clog2(NAME_BUFFER_CHARS);
  localparam logic [23:0] POS_LIMIT =
    ((MAX_TEXT - 1) < 16777215) ? 24'(MAX_TEXT - 1) : 24'hFFFFFF;
  localparam logic [15:0] NAME_CHARS = 16'(NAME_BUFFER_CHARS);

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_NUM        = 4'd1;
  localparam logic [3:0] M_IDENT      = 4'd2;
  localparam logic [3:0] M_OP         = 4'd3;
  localparam logic [3:0] M_CHAR_OPEN  = 4'd4;
  localparam logic [3:0] M_CHAR_ESC   = 4'd5;
  localparam logic [3:0] M_CHAR_CLOSE = 4'd6;
  localparam logic [3:0] M_STR        = 4'd7;
  localparam logic [3:0] M_STR_ESC    = 4'd8;
  localparam logic [3:0] M_SKIP       = 4'd9;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;

  logic [3:0]  mode, mode_next;
  logic [7:0]  pend, pend_next;
  logic [31:0] acc, acc_next;
  logic [23:0] tstart, tstart_next;
  logic [23:0] tpos, tpos_next;
  logic [NAME_BUFFER_CHARS-1:0][7:0] nbuf, nbuf_next;
  logic [15:0] nlen, nlen_next;
  logic [23:0] tcount, tcount_next;
  logic [15:0] slen, slen_next;

  ctlex_pkg::result_t res [2];
  logic [1:0]  nres;
  logic        do_start;
  logic        emit_num, emit_id, emit_op, emit_str;
  logic [8*ctlex_pkg::KW_CHARS-1:0] kw_word;
  logic [3:0]  kw_code;

  always_comb begin
    for (int i = 0; i < ctlex_pkg::KW_CHARS; i++) begin
      kw_word[8*(ctlex_pkg::KW_CHARS-1-i) +: 8] = nbuf[i];
    end
    kw_code = ctlex_pkg::keyword_of(kw_word, nlen);
  end

  always_comb begin
    mode_next = mode;
    pend_next = pend;
    acc_next = acc;
    tstart_next = tstart;
    tpos_next = tpos;
    nbuf_next = nbuf;
    nlen_next = nlen;
    tcount_next = tcount;
    slen_next = slen;
    res[0] = '0;
    res[1] = '0;
    nres = 2'd0;
    do_start = 1'b0;
    emit_num = 1'b0;
    emit_id = 1'b0;
    emit_op = 1'b0;
    emit_str = 1'b0;

    if (text_byte == 8'd0) begin
      unique case (mode)
        M_NUM, M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: emit_num = 1'b1;
        M_IDENT: emit_id = 1'b1;
        M_OP: emit_op = 1'b1;
        M_STR, M_STR_ESC: emit_str = 1'b1;
        default: ;
      endcase
    end else begin
      unique case (mode)
        M_NUM: begin
          if (ctlex_pkg::is_digit(text_byte)) begin
            acc_next = (acc << 3) + (acc << 1) + {28'd0, text_byte[3:0]};
          end else begin
            emit_num = 1'b1;
            do_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (ctlex_pkg::is_alpha(text_byte) || ctlex_pkg::is_digit(text_byte)) begin
            if (nlen < NAME_CHARS) begin
              nbuf_next[nlen[IDX_W-1:0]] = text_byte;
            end
            nlen_next = ctlex_pkg::inc_sat16(nlen);
          end else begin
            emit_id = 1'b1;
            do_start = 1'b1;
          end
        end
        M_OP: begin
          if (ctlex_pkg::is_op_tail(text_byte)) begin
            res[nres[0]] = '{ctlex_pkg::KIND_OPER, {24'd0, pend}, text_byte, 4'd0,
                             tstart, 16'd2};
            nres = nres + 2'd1;
            tcount_next = ctlex_pkg::inc_sat24(tcount_next);
            mode_next = M_IDLE;
          end else if ((pend == CH_SLASH) && (text_byte == CH_SLASH)) begin
            mode_next = M_SKIP;
          end else begin
            emit_op = 1'b1;
            do_start = 1'b1;
          end
        end
        M_CHAR_OPEN: begin
          if (text_byte == CH_BSLASH) begin
            mode_next = M_CHAR_ESC;
          end else begin
            acc_next = {24'd0, text_byte};
            mode_next = M_CHAR_CLOSE;
          end
        end
        M_CHAR_ESC: begin
          priority if (text_byte == CH_N) acc_next = 32'd10;
          else if (text_byte == CH_BSLASH) acc_next = 32'd92;
          else if (text_byte == CH_QUOTE) acc_next = 32'd39;
          else acc_next = 32'd0;
          mode_next = M_CHAR_CLOSE;
        end
        M_CHAR_CLOSE: begin
          emit_num = 1'b1;
          mode_next = M_IDLE;
        end
        M_STR: begin
          priority if (text_byte == CH_DQUOTE) begin
            emit_str = 1'b1;
            mode_next = M_IDLE;
          end else if (text_byte == CH_BSLASH) begin
            mode_next = M_STR_ESC;
          end else begin
            res[nres[0]] = '{ctlex_pkg::KIND_STRBYTE, {24'd0, text_byte}, 8'd0, 4'd0,
                             tpos, 16'd0};
            nres = nres + 2'd1;
            slen_next = ctlex_pkg::inc_sat16(slen);
          end
        end
        M_STR_ESC: begin
          res[nres[0]] = '{ctlex_pkg::KIND_STRBYTE,
                           (text_byte == CH_N) ? 32'd10 : {24'd0, text_byte},
                           8'd0, 4'd0, tpos, 16'd0};
          nres = nres + 2'd1;
          slen_next = ctlex_pkg::inc_sat16(slen);
          mode_next = M_STR;
        end
        M_SKIP: begin
          if (text_byte == CH_NL) begin
            mode_next = M_IDLE;
          end
        end
        default: do_start = 1'b1;
      endcase
    end

    // Pending token closed by this byte.
    if (emit_num) begin
      res[nres[0]] = '{ctlex_pkg::KIND_NUMBER, acc, 8'd0, 4'd0, tstart, 16'd0};
      nres = nres + 2'd1;
      tcount_next = ctlex_pkg::inc_sat24(tcount_next);
    end
    if (emit_id) begin
      res[nres[0]] = '{ctlex_pkg::KIND_IDENT, 32'd0, 8'd0, kw_code, tstart, nlen};
      nres = nres + 2'd1;
      tcount_next = ctlex_pkg::inc_sat24(tcount_next);
    end
    if (emit_op) begin
      res[nres[0]] = '{ctlex_pkg::KIND_OPER, {24'd0, pend}, 8'd0, 4'd0, tstart, 16'd1};
      nres = nres + 2'd1;
      tcount_next = ctlex_pkg::inc_sat24(tcount_next);
    end
    if (emit_str) begin
      res[nres[0]] = '{ctlex_pkg::KIND_STRING, 32'd0, 8'd0, 4'd0, tstart, slen};
      nres = nres + 2'd1;
      tcount_next = ctlex_pkg::inc_sat24(tcount_next);
    end

    if (do_start) begin
      mode_next = M_IDLE;
      priority if (text_byte == CH_HASH) begin
        mode_next = M_SKIP;
      end else if (ctlex_pkg::is_digit(text_byte)) begin
        mode_next = M_NUM;
        acc_next = {28'd0, text_byte[3:0]};
        tstart_next = tpos;
      end else if (text_byte == CH_QUOTE) begin
        mode_next = M_CHAR_OPEN;
        acc_next = 32'd0;
        tstart_next = tpos;
      end else if (text_byte == CH_DQUOTE) begin
        mode_next = M_STR;
        slen_next = 16'd0;
        tstart_next = tpos;
      end else if (ctlex_pkg::is_alpha(text_byte)) begin
        mode_next = M_IDENT;
        nbuf_next = '0;
        nbuf_next[0] = text_byte;
        nlen_next = 16'd1;
        tstart_next = tpos;
      end else if (ctlex_pkg::is_op_lead(text_byte)) begin
        mode_next = M_OP;
        pend_next = text_byte;
        tstart_next = tpos;
      end else if (ctlex_pkg::is_punct(text_byte)) begin
        res[nres[0]] = '{ctlex_pkg::KIND_PUNCT, {24'd0, text_byte}, 8'd0, 4'd0, tpos,
                         16'd1};
        nres = nres + 2'd1;
        tcount_next = ctlex_pkg::inc_sat24(tcount_next);
      end else begin
        mode_next = M_IDLE;
      end
    end

    if (text_byte == 8'd0) begin
      res[nres[0]] = '{ctlex_pkg::KIND_END, {8'd0, tcount_next}, 8'd0, 4'd0, tpos, 16'd0};
      nres = nres + 2'd1;
      mode_next = M_IDLE;
      pend_next = 8'd0;
      acc_next = 32'd0;
      tstart_next = 24'd0;
      tpos_next = 24'd0;
      nbuf_next = '0;
      nlen_next = 16'd0;
      tcount_next = 24'd0;
      slen_next = 16'd0;
    end else if (tpos < POS_LIMIT) begin
      tpos_next = tpos + 24'd1;
    end
  end

  assign push = accept && (nres != 2'd0);
  assign group = '{(nres == 2'd2), res[0], res[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pend <= 8'd0;
      acc <= 32'd0;
      tstart <= 24'd0;
      tpos <= 24'd0;
      nbuf <= '0;
      nlen <= 16'd0;
      tcount <= 24'd0;
      slen <= 16'd0;
    end else if (accept) begin
      mode <= mode_next;
      pend <= pend_next;
      acc <= acc_next;
      tstart <= tstart_next;
      tpos <= tpos_next;
      nbuf <= nbuf_next;
      nlen <= nlen_next;
      tcount <= tcount_next;
      slen <= slen_next;
    end
  end

endmodule

### design/ctlex_queue.sv
module ctlex_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ctlex_pkg::group_t push_data,
  input  logic              pop,
  output ctlex_pkg::group_t head,
  output logic [$clog2(ctlex_pkg::QUEUE_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(ctlex_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ctlex_pkg::QUEUE_DEPTH + 1);

  ctlex_pkg::group_t entries [ctlex_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;

  assign head = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PTR_W'(1);
      if (pop) rptr <= rptr + PTR_W'(1);
      unique case ({push, pop})
        2'b10: count <= count + CNT_W'(1);
        2'b01: count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### design/ctlex_back.sv
module ctlex_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  ctlex_pkg::group_t  head,
  output logic               pop,
  output logic               sel,
  output logic               token_valid,
  input  logic               token_ready,
  output ctlex_pkg::result_t token,
  output logic               last
);

  logic load;

  assign load = !token_valid || token_ready;
  assign pop = load && nonempty && (!head.two || sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      sel <= 1'b0;
    end else if (load) begin
      token_valid <= nonempty;
      if (nonempty) begin
        sel <= head.two && !sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && nonempty) begin
      token <= sel ? head.tail : head.lead;
      last <= !head.two || sel;
    end
  end

endmodule

### tb/tb_c_subset_token_lexer.sv
`timescale 1ns / 1ps
module tb_c_subset_token_lexer;

  typedef enum logic [3:0] {
    LX_IDLE, LX_NUM, LX_IDENT, LX_OP, LX_CHR_OPEN, LX_CHR_ESC, LX_CHR_CLOSE,
    LX_STR, LX_STR_ESC, LX_SKIP
  } lex_mode_e;

  typedef enum logic [3:0] {
    KWC_PLAIN, KWC_INT, KWC_CHAR, KWC_IF, KWC_ELSE, KWC_RETURN, KWC_PRINTF,
    KWC_MEMCMP, KWC_MALLOC, KWC_MEMCHR, KWC_MEMMOVE, KWC_FOPEN, KWC_FREAD, KWC_EXIT
  } kw_code_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [7:0]  second;
    logic [3:0]  keyword;
    logic [23:0] start;
    logic [15:0] length;
    logic        last;
  } token_rec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       drain;
  } text_item_t;

  localparam logic [23:0] OFFSET_MAX = 24'hFFFFFF;
  localparam int NAME_KEEP = 7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_QUIET = 160;
  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic [7:0]  text_byte = 8'h00;
  logic        token_valid;
  logic        token_ready = 1'b0;
  logic [2:0]  token_kind;
  logic [31:0] token_value;
  logic [7:0]  second_char;
  logic [3:0]  keyword_code;
  logic [23:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  c_subset_token_lexer i_dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .token_value  (token_value),
    .second_char  (second_char),
    .keyword_code (keyword_code),
    .start_offset (start_offset),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  always #2 clk = ~clk;

  lex_mode_e   lx_mode;
  logic [7:0]  op_first;
  logic [31:0] num_acc;
  logic [23:0] tok_start;
  logic [23:0] text_pos;
  logic [23:0] tok_total;
  logic [7:0]  name_chars [NAME_KEEP];
  logic [15:0] name_len;
  logic [15:0] str_len;

  token_rec_t step_res [2];
  int         step_n;

  token_rec_t expected_tokens [$];
  text_item_t source_bytes [$];

  int  bytes_taken = 0;
  int  total_bytes = 0;
  int  mismatches = 0;
  int  tokens_seen = 0;
  int  quiet_cycles = 0;
  logic quiet_tail = 1'b0;

  function automatic void clear_lexer();
    lx_mode = LX_IDLE;
    op_first = 8'h00;
    num_acc = 32'd0;
    tok_start = 24'd0;
    text_pos = 24'd0;
    tok_total = 24'd0;
    for (int i = 0; i < NAME_KEEP; i++) name_chars[i] = 8'h00;
    name_len = 16'd0;
    str_len = 16'd0;
  endfunction

  function automatic logic is_num_char(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return b == "_" || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic kw_code_e name_keyword();
    logic [55:0] word;
    word = {name_chars[0], name_chars[1], name_chars[2], name_chars[3],
            name_chars[4], name_chars[5], name_chars[6]};
    if (name_len > 16'(NAME_KEEP)) return KWC_PLAIN;
    case (word)
      {"int", 32'd0}:    return KWC_INT;
      {"char", 24'd0}:   return KWC_CHAR;
      {"if", 40'd0}:     return KWC_IF;
      {"else", 24'd0}:   return KWC_ELSE;
      {"FILE", 24'd0}:   return KWC_CHAR;
      {"return", 8'd0}:  return KWC_RETURN;
      {"printf", 8'd0}:  return KWC_PRINTF;
      {"memcmp", 8'd0}:  return KWC_MEMCMP;
      {"malloc", 8'd0}:  return KWC_MALLOC;
      {"memchr", 8'd0}:  return KWC_MEMCHR;
      "memmove":         return KWC_MEMMOVE;
      {"fopen", 16'd0}:  return KWC_FOPEN;
      {"fread", 16'd0}:  return KWC_FREAD;
      {"exit", 24'd0}:   return KWC_EXIT;
      default:           return KWC_PLAIN;
    endcase
  endfunction

  function automatic void add_tok(input logic [2:0] kind, input logic [31:0] value,
                                  input logic [7:0] second, input logic [3:0] keyword,
                                  input logic [23:0] start, input logic [15:0] length);
    if (step_n < 2) begin
      step_res[step_n] = '{kind, value, second, keyword, start, length, 1'b0};
      step_n++;
    end
  endfunction

  function automatic void bump_total();
    if (tok_total != OFFSET_MAX) tok_total++;
  endfunction

  function automatic void emit_number();
    add_tok(ctlex_pkg::KIND_NUMBER, num_acc, 8'h00, KWC_PLAIN, tok_start, 16'd0);
    bump_total();
  endfunction

  function automatic void emit_name();
    add_tok(ctlex_pkg::KIND_IDENT, 32'd0, 8'h00, name_keyword(), tok_start, name_len);
    bump_total();
  endfunction

  function automatic void emit_single_op();
    add_tok(ctlex_pkg::KIND_OPER, {24'd0, op_first}, 8'h00, KWC_PLAIN, tok_start, 16'd1);
    bump_total();
  endfunction

  function automatic void emit_string();
    add_tok(ctlex_pkg::KIND_STRING, 32'd0, 8'h00, KWC_PLAIN, tok_start, str_len);
    bump_total();
  endfunction

  function automatic void emit_str_byte(input logic [7:0] v, input logic [23:0] pos);
    add_tok(ctlex_pkg::KIND_STRBYTE, {24'd0, v}, 8'h00, KWC_PLAIN, pos, 16'd0);
    if (str_len != 16'hFFFF) str_len++;
  endfunction

  function automatic void begin_token(input logic [7:0] b, input logic [23:0] pos);
    lx_mode = LX_IDLE;
    if (b == "#") begin
      lx_mode = LX_SKIP;
    end else if (is_num_char(b)) begin
      lx_mode = LX_NUM;
      num_acc = {24'd0, b - "0"};
      tok_start = pos;
    end else if (b == "'") begin
      lx_mode = LX_CHR_OPEN;
      num_acc = 32'd0;
      tok_start = pos;
    end else if (b == "\"") begin
      lx_mode = LX_STR;
      str_len = 16'd0;
      tok_start = pos;
    end else if (is_name_char(b)) begin
      lx_mode = LX_IDENT;
      for (int i = 0; i < NAME_KEEP; i++) name_chars[i] = 8'h00;
      name_chars[0] = b;
      name_len = 16'd1;
      tok_start = pos;
    end else if (b inside {"*", "/", "+", "-", "<", "=", ">", "|", "&", "!"}) begin
      lx_mode = LX_OP;
      op_first = b;
      tok_start = pos;
    end else if (b inside {"(", ")", "{", "}", ",", ";"}) begin
      add_tok(ctlex_pkg::KIND_PUNCT, {24'd0, b}, 8'h00, KWC_PLAIN, pos, 16'd1);
      bump_total();
    end
  endfunction

  function automatic void lex_byte(input logic [7:0] b);
    logic [23:0] pos;
    token_rec_t  rec;
    pos = text_pos;
    step_n = 0;
    if (b == 8'h00) begin
      case (lx_mode)
        LX_NUM, LX_CHR_OPEN, LX_CHR_ESC, LX_CHR_CLOSE: emit_number();
        LX_IDENT: emit_name();
        LX_OP: emit_single_op();
        LX_STR, LX_STR_ESC: emit_string();
        default: ;
      endcase
      add_tok(ctlex_pkg::KIND_END, {8'd0, tok_total}, 8'h00, KWC_PLAIN, pos, 16'd0);
      clear_lexer();
    end else begin
      case (lx_mode)
        LX_NUM: begin
          if (is_num_char(b)) begin
            num_acc = num_acc * 32'd10 + {24'd0, b - "0"};
          end else begin
            emit_number();
            begin_token(b, pos);
          end
        end
        LX_IDENT: begin
          if (is_name_char(b) || is_num_char(b)) begin
            if (name_len < 16'(NAME_KEEP)) name_chars[name_len[2:0]] = b;
            if (name_len != 16'hFFFF) name_len++;
          end else begin
            emit_name();
            begin_token(b, pos);
          end
        end
        LX_OP: begin
          if (b inside {"=", "&", "|"}) begin
            add_tok(ctlex_pkg::KIND_OPER, {24'd0, op_first}, b, KWC_PLAIN, tok_start,
                    16'd2);
            bump_total();
            lx_mode = LX_IDLE;
          end else if (op_first == "/" && b == "/") begin
            lx_mode = LX_SKIP;
          end else begin
            emit_single_op();
            begin_token(b, pos);
          end
        end
        LX_CHR_OPEN: begin
          if (b == "\\") begin
            lx_mode = LX_CHR_ESC;
          end else begin
            num_acc = {24'd0, b};
            lx_mode = LX_CHR_CLOSE;
          end
        end
        LX_CHR_ESC: begin
          num_acc = (b == "n") ? {24'd0, "\n"} : (b == "\\") ? {24'd0, "\\"} :
                    (b == "'") ? {24'd0, "'"} : 32'd0;
          lx_mode = LX_CHR_CLOSE;
        end
        LX_CHR_CLOSE: begin
          emit_number();
          lx_mode = LX_IDLE;
        end
        LX_STR: begin
          if (b == "\"") begin
            emit_string();
            lx_mode = LX_IDLE;
          end else if (b == "\\") begin
            lx_mode = LX_STR_ESC;
          end else begin
            emit_str_byte(b, pos);
          end
        end
        LX_STR_ESC: begin
          emit_str_byte((b == "n") ? 8'h0A : b, pos);
          lx_mode = LX_STR;
        end
        LX_SKIP: begin
          if (b == "\n") lx_mode = LX_IDLE;
        end
        default: begin
          begin_token(b, pos);
        end
      endcase
      if (text_pos != OFFSET_MAX) text_pos++;
    end
    for (int i = 0; i < step_n; i++) begin
      rec = step_res[i];
      rec.last = (i == step_n - 1);
      expected_tokens.push_back(rec);
    end
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    text_item_t it;
    it.ch = c;
    it.drain = 1'b0;
    source_bytes.push_back(it);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] rand_alpha();
    int r;
    r = int'($urandom_range(0, 52));
    if (r == 52) return "_";
    if (r < 26) return 8'(65 + r);
    return 8'(97 + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(48 + $urandom_range(0, 9));
  endfunction

  function automatic string kw_text(input int i);
    case (i)
      0: return "int";
      1: return "char";
      2: return "if";
      3: return "else";
      4: return "FILE";
      5: return "return";
      6: return "printf";
      7: return "memcmp";
      8: return "malloc";
      9: return "memchr";
      10: return "memmove";
      11: return "fopen";
      12: return "fread";
      13: return "exit";
      14: return "ints";
      15: return "els";
      16: return "memmoves";
      default: return "Int";
    endcase
  endfunction

  function automatic void gen_token();
    int sel;
    int n;
    logic [7:0] c;
    sel = int'($urandom_range(0, 19));
    if (sel < 4) begin
      n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(5, 12)) :
                                        int'($urandom_range(1, 3));
      repeat (n) add_byte(rand_digit());
    end else if (sel < 8) begin
      if ($urandom_range(0, 2) == 0) begin
        add_text(kw_text(int'($urandom_range(0, 17))));
      end else begin
        n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 20)) :
                                          int'($urandom_range(1, 6));
        add_byte(rand_alpha());
        repeat (n - 1) add_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha());
      end
    end else if (sel < 11) begin
      add_byte(pick_char("*/+-<=>|&!"));
      if ($urandom_range(0, 1) == 0) add_byte(pick_char("=&|"));
    end else if (sel < 13) begin
      add_byte(pick_char("(){},;"));
    end else if (sel == 13) begin
      add_byte("'");
      if ($urandom_range(0, 2) == 0) begin
        add_byte("\\");
        add_byte(($urandom_range(0, 1) == 0) ? pick_char("n\\'xq") : any_byte());
      end else begin
        add_byte(any_byte());
      end
      add_byte(($urandom_range(0, 3) != 0) ? 8'h27 : any_byte());
    end else if (sel == 14) begin
      add_byte("\"");
      n = int'($urandom_range(0, 8));
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) begin
          add_byte("\\");
          add_byte(($urandom_range(0, 1) == 0) ? pick_char("n\\\"t") : any_byte());
        end else begin
          do begin
            c = 8'($urandom_range(32, 126));
          end while (c == "\"" || c == "\\");
          add_byte(c);
        end
      end
      add_byte("\"");
    end else if (sel == 15) begin
      if ($urandom_range(0, 1) == 0) add_text("//");
      else add_byte("#");
      n = int'($urandom_range(0, 6));
      repeat (n) begin
        c = any_byte();
        add_byte((c == "\n") ? 8'h78 : c);
      end
      add_byte("\n");
    end else if (sel == 16) begin
      case ($urandom_range(0, 4))
        0: add_text("\"");
        1: add_text("'");
        2: add_text("'\\");
        3: add_text("/");
        default: add_text("//");
      endcase
    end else begin
      case ($urandom_range(0, 4))
        0: add_byte(" ");
        1: add_byte("\n");
        2: add_byte("\t");
        default: add_byte(any_byte());
      endcase
    end
  endfunction

  function automatic void report(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  // Sender: holds each byte until its transfer, with random idle bursts.
  always @(posedge clk) begin
    int gap_left;
    if (rst) begin
      text_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (text_valid && text_ready) begin
        lex_byte(text_byte);
        bytes_taken++;
      end
      quiet_tail <= (source_bytes.size() < TAIL_QUIET);
      if (text_valid && !text_ready) begin
        text_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        text_valid <= 1'b0;
      end else if (source_bytes.size() != 0 &&
                   !(source_bytes[0].drain && expected_tokens.size() != 0)) begin
        if (source_bytes.size() >= TAIL_QUIET && $urandom_range(0, 9) == 0) begin
          gap_left = int'($urandom_range(0, 10));
          text_valid <= 1'b0;
        end else begin
          text_byte <= source_bytes[0].ch;
          text_valid <= 1'b1;
          void'(source_bytes.pop_front());
        end
      end else begin
        text_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each transfer and stalls in random bursts, once for a long stretch.
  always @(posedge clk) begin
    int stall_left;
    int hold_left;
    bit held_once;
    token_rec_t want;
    if (rst) begin
      token_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      held_once = 1'b0;
    end else begin
      if (token_valid && token_ready) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          report("token_kind (unexpected token)", 32'hFFFFFFFF, 32'(token_kind));
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind !== want.kind) report("token_kind", 32'(want.kind), 32'(token_kind));
          if (token_value !== want.value) report("token_value", want.value, token_value);
          if (second_char !== want.second)
            report("second_char", 32'(want.second), 32'(second_char));
          if (keyword_code !== want.keyword)
            report("keyword_code", 32'(want.keyword), 32'(keyword_code));
          if (start_offset !== want.start)
            report("start_offset", 32'(want.start), 32'(start_offset));
          if (token_length !== want.length)
            report("token_length", 32'(want.length), 32'(token_length));
          if (last_of_run !== want.last)
            report("last_of_run", 32'(want.last), 32'(last_of_run));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        token_ready <= 1'b0;
      end else if (!held_once && tokens_seen >= 400) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD - 1;
        token_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        token_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left = int'($urandom_range(0, 10));
        token_ready <= 1'b0;
      end else begin
        token_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_valid && text_ready) || (token_valid && token_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    text_item_t it;
    clear_lexer();
    add_text("'\\n");
    add_byte(8'h00);
    add_text("\"a\\");
    add_byte(8'h00);
    add_text("//x");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("#");
    add_byte(8'h00);
    add_text("x!=(");
    add_byte(8'h00);
    add_text("'ab");
    add_byte(8'h00);
    while (source_bytes.size() < 1620) begin
      repeat ($urandom_range(3, 30)) gen_token();
      add_byte(8'h00);
    end
    it = source_bytes[700];
    it.drain = 1'b1;
    source_bytes[700] = it;
    it = source_bytes[1300];
    it.drain = 1'b1;
    source_bytes[1300] = it;
    total_bytes = source_bytes.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (bytes_taken < total_bytes) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/ctlex_pkg.sv
design/ctlex_front.sv
design/ctlex_queue.sv
design/ctlex_back.sv
design/c_subset_token_lexer.sv
tb/tb_c_subset_token_lexer.sv
